/* rtl/core/lhr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED HSL to RGB package
// Shared payload types, fixed-point constants and stage records for the
// LED HSL to RGB conversion pipeline.
// ----------------------------------------------------------------------------
package lhr_pkg;

    // Number of LEDs on the strip; the hue sweeps once round the wheel over it.
    localparam int LED_COUNT = 32;
    localparam logic [10:0] LED_COUNT_V = 11'(LED_COUNT);

    // Input transaction payload.
    typedef struct packed {
        logic [9:0] led_index;
        logic [7:0] lightness;
    } lhr_in_t;

    // Result transaction payload.
    typedef struct packed {
        logic [9:0] slot;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } lhr_out_t;

    localparam logic [7:0] SAT_RESET = 8'd255;

    // Exact floor division by the LED count through a rounded-up reciprocal.
    // With 21 fraction bits the error term stays below one step for any
    // dividend and divisor of up to ten bits.
    localparam int HUE_SHIFT = 21;
    localparam logic [21:0] IDX_RECIP =
        22'(((longint'(1) << HUE_SHIFT) + LED_COUNT - 1) / LED_COUNT);
    localparam logic [29:0] DEG_RECIP =
        30'((longint'(360) * (longint'(1) << HUE_SHIFT) + LED_COUNT - 1) / LED_COUNT);

    // Channels are numerators over 2*255*60; the floor uses a reciprocal with
    // 39 fraction bits, enough for exact results on 24-bit numerators.
    localparam int DENOM = 30600;
    localparam logic [14:0] DENOM_V = 15'(DENOM);
    localparam int CHAN_NUM_W = 24;
    localparam int CHAN_RECIP_W = 25;
    localparam int CHAN_SHIFT = 39;
    localparam logic [CHAN_RECIP_W-1:0] CHAN_RECIP =
        CHAN_RECIP_W'(((longint'(1) << CHAN_SHIFT) + DENOM - 1) / DENOM);

    // Hue sextant codes.
    localparam logic [2:0] SEXT_RED_YEL  = 3'd0;
    localparam logic [2:0] SEXT_YEL_GRN  = 3'd1;
    localparam logic [2:0] SEXT_GRN_CYN  = 3'd2;
    localparam logic [2:0] SEXT_CYN_BLU  = 3'd3;
    localparam logic [2:0] SEXT_BLU_MAG  = 3'd4;
    localparam logic [2:0] SEXT_MAG_RED  = 3'd5;

    // Hue path record at the end of its fourth stage.
    typedef struct packed {
        logic       valid;
        logic [9:0] slot;
        logic [2:0] sext;
        logic [5:0] mult;
    } hue_stage_t;

    // Lightness path record at the end of its fourth stage.
    typedef struct packed {
        logic        grey;
        logic [7:0]  lum;
        logic [15:0] as;
        logic [22:0] base;
        logic [23:0] cnum;
    } lvl_stage_t;

endpackage

/* rtl/core/led_hsl_to_rgb_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED HSL to RGB conversion unit
// Converts an LED position and lightness byte into an RGB color whose hue
// sweeps the color wheel along the strip, at the programmed saturation.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake           Payload
//  s_        in   s_valid / s_ready   lhr_in_t  {led_index, lightness}
//  m_        out  m_valid / m_ready   lhr_out_t {slot, red, green, blue}
//  cfg_      in   cfg_valid / cfg_ready  8-bit saturation
//
// The pipeline has seven register stages and accepts one transaction per
// cycle; a result passes through all seven before it appears at the output.
// The rate is set by the single shared stage enable: every stage moves while
// the output register is empty or being taken, so a stall freezes the whole
// pipeline in place and nothing is lost or repeated.
// Reset clears every valid bit and sets saturation to full (255).
// Saturation writes are always taken and apply to inputs accepted afterwards.
//
module led_hsl_to_rgb_unit (
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              s_valid,
    output logic              s_ready,
    input  lhr_pkg::lhr_in_t  s_data,

    output logic              m_valid,
    input  logic              m_ready,
    output lhr_pkg::lhr_out_t m_data,

    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [7:0]        cfg_data
);

    logic [7:0] sat_reg;
    logic [7:0] sat_next;
    logic       en;
    logic       out_valid;

    lhr_pkg::hue_stage_t hue_stage;
    lhr_pkg::lvl_stage_t lvl_stage;

    // The pipeline advances whenever the output register can take a new
    // value, i.e. it is empty or its transaction completes this cycle.
    assign en      = !out_valid || m_ready;
    assign s_ready = en;

    // The configuration register never back-pressures.
    assign cfg_ready = 1'b1;
    assign sat_next  = (cfg_valid && cfg_ready) ? cfg_data : sat_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sat_reg <= lhr_pkg::SAT_RESET;
        end else begin
            sat_reg <= sat_next;
        end
    end

    // Hue path: index modulo count, hue, sextant and offset multiplier.
    lhr_hue_pipe u_hue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .led_index (s_data.led_index),
        .stage_out (hue_stage)
    );

    // Lightness path: chroma factor, base and chroma numerators.
    lhr_level_pipe u_level (
        .aclk       (aclk),
        .en         (en),
        .lightness  (s_data.lightness),
        .saturation (sat_reg),
        .stage_out  (lvl_stage)
    );

    // Offset numerator, exact flooring and placement into R, G and B.
    lhr_channel_pipe u_channel (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .hue_in    (hue_stage),
        .lvl_in    (lvl_stage),
        .out_valid (out_valid),
        .out_data  (m_data)
    );

    assign m_valid = out_valid;

endmodule

/* rtl/core/lhr_hue_pipe.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED HSL to RGB hue path
// Four stages from LED index to hue sextant and offset multiplier.
// ----------------------------------------------------------------------------
module lhr_hue_pipe (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  logic [9:0]         led_index,
    output lhr_pkg::hue_stage_t stage_out
);

    logic       v1_reg, v2_reg, v3_reg, v4_reg;
    logic [9:0] slot1_reg, slot2_reg, slot3_reg, slot4_reg;
    logic [30:0] p1_reg;
    logic [9:0]  r_reg;
    logic [29:0] p2_reg;
    logic [2:0]  sext_reg;
    logic [5:0]  mult_reg;

    logic [31:0] p1_full;
    logic [30:0] p1_next;
    logic [9:0]  q1;
    logic [20:0] qc;
    logic [9:0]  r_next;
    logic [39:0] p2_full;
    logic [29:0] p2_next;
    logic [8:0]  hue;
    logic [8:0]  hm_w;
    logic [6:0]  hm;
    logic [5:0]  dev;
    logic [2:0]  sext_next;
    logic [5:0]  mult_next;

    // Stage 1: index times reciprocal of the LED count.
    assign p1_full = {22'd0, led_index} * {10'd0, lhr_pkg::IDX_RECIP};
    assign p1_next = p1_full[30:0];

    // Stage 2: remainder of the index modulo the LED count.
    assign q1     = p1_reg[30:21];
    assign qc     = 21'(q1) * lhr_pkg::LED_COUNT_V;
    assign r_next = slot1_reg - qc[9:0];

    // Stage 3: hue as remainder times 360 over the LED count.
    assign p2_full = {30'd0, r_reg} * {10'd0, lhr_pkg::DEG_RECIP};
    assign p2_next = p2_full[29:0];

    // Stage 4: sextant and distance from the nearest primary.
    assign hue = p2_reg[29:21];

    always_comb begin
        if (hue < 9'd60) begin
            sext_next = lhr_pkg::SEXT_RED_YEL;
        end else if (hue < 9'd120) begin
            sext_next = lhr_pkg::SEXT_YEL_GRN;
        end else if (hue < 9'd180) begin
            sext_next = lhr_pkg::SEXT_GRN_CYN;
        end else if (hue < 9'd240) begin
            sext_next = lhr_pkg::SEXT_CYN_BLU;
        end else if (hue < 9'd300) begin
            sext_next = lhr_pkg::SEXT_BLU_MAG;
        end else begin
            sext_next = lhr_pkg::SEXT_MAG_RED;
        end
    end

    always_comb begin
        if (hue >= 9'd240) begin
            hm_w = hue - 9'd240;
        end else if (hue >= 9'd120) begin
            hm_w = hue - 9'd120;
        end else begin
            hm_w = hue;
        end
    end

    assign hm        = hm_w[6:0];
    assign dev       = (hm >= 7'd60) ? 6'(hm - 7'd60) : 6'(7'd60 - hm);
    assign mult_next = 6'd60 - dev;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            slot1_reg <= led_index;
            p1_reg    <= p1_next;
            slot2_reg <= slot1_reg;
            r_reg     <= r_next;
            slot3_reg <= slot2_reg;
            p2_reg    <= p2_next;
            slot4_reg <= slot3_reg;
            sext_reg  <= sext_next;
            mult_reg  <= mult_next;
        end
    end

    assign stage_out.valid = v4_reg;
    assign stage_out.slot  = slot4_reg;
    assign stage_out.sext  = sext_reg;
    assign stage_out.mult  = mult_reg;

endmodule

/* rtl/core/lhr_level_pipe.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED HSL to RGB lightness path
// Four stages from lightness and saturation to the base and chroma numerators.
// ----------------------------------------------------------------------------
module lhr_level_pipe (
    input  logic               aclk,
    input  logic               en,
    input  logic [7:0]         lightness,
    input  logic [7:0]         saturation,
    output lhr_pkg::lvl_stage_t stage_out
);

    logic [7:0]  lum1_reg, lum2_reg, lum3_reg, lum4_reg;
    logic        grey1_reg, grey2_reg, grey3_reg, grey4_reg;
    logic [15:0] as1_reg, as2_reg, as3_reg, as4_reg;
    logic [22:0] base2_reg, base3_reg, base4_reg;
    logic [23:0] cnum3_reg, cnum4_reg;

    logic [8:0]  twol;
    logic [8:0]  a_w;
    logic [15:0] as_next;
    logic [22:0] base_next;
    logic [23:0] cnum_next;

    // Stage 1: A = 255 - |2l - 255|, scaled by saturation.
    assign twol    = {lightness, 1'b0};
    assign a_w     = (twol >= 9'd255) ? (9'd510 - twol) : twol;
    assign as_next = 16'(a_w[7:0]) * 16'(saturation);

    // Stage 2: base numerator; never negative for valid byte inputs.
    assign base_next = 23'(lum1_reg) * 23'(lhr_pkg::DENOM_V) - 23'(as1_reg) * 23'd60;

    // Stage 3: chroma numerator.
    assign cnum_next = 24'(base2_reg) + 24'(as2_reg) * 24'd120;

    always_ff @(posedge aclk) begin
        if (en) begin
            lum1_reg  <= lightness;
            grey1_reg <= (saturation == 8'd0);
            as1_reg   <= as_next;

            lum2_reg  <= lum1_reg;
            grey2_reg <= grey1_reg;
            as2_reg   <= as1_reg;
            base2_reg <= base_next;

            lum3_reg  <= lum2_reg;
            grey3_reg <= grey2_reg;
            as3_reg   <= as2_reg;
            base3_reg <= base2_reg;
            cnum3_reg <= cnum_next;

            lum4_reg  <= lum3_reg;
            grey4_reg <= grey3_reg;
            as4_reg   <= as3_reg;
            base4_reg <= base3_reg;
            cnum4_reg <= cnum3_reg;
        end
    end

    assign stage_out.grey = grey4_reg;
    assign stage_out.lum  = lum4_reg;
    assign stage_out.as   = as4_reg;
    assign stage_out.base = base4_reg;
    assign stage_out.cnum = cnum4_reg;

endmodule

/* rtl/core/lhr_channel_pipe.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED HSL to RGB channel stages
// Offset numerator, exact floor of the three levels, sextant placement.
// ----------------------------------------------------------------------------
module lhr_channel_pipe (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  lhr_pkg::hue_stage_t hue_in,
    input  lhr_pkg::lvl_stage_t lvl_in,
    output logic                out_valid,
    output lhr_pkg::lhr_out_t   out_data
);

    logic        v5_reg, v6_reg, out_valid_reg;
    logic [9:0]  slot5_reg, slot6_reg;
    logic [2:0]  sext5_reg, sext6_reg;
    logic        grey5_reg, grey6_reg;
    logic [7:0]  lum5_reg, lum6_reg;
    logic [23:0] onum5_reg, cnum5_reg, base5_reg;
    logic [9:0]  oq_reg, cq_reg, bq_reg;
    lhr_pkg::lhr_out_t out_data_reg;
    lhr_pkg::lhr_out_t out_data_next;

    logic [23:0] prodm;
    logic [23:0] onum_next;
    logic [7:0]  oc, cc, bc;

    function automatic logic [9:0] chan_quot(input logic [23:0] num);
        logic [lhr_pkg::CHAN_NUM_W+lhr_pkg::CHAN_RECIP_W-1:0] prod;
        prod = (lhr_pkg::CHAN_NUM_W + lhr_pkg::CHAN_RECIP_W)'(num)
             * (lhr_pkg::CHAN_NUM_W + lhr_pkg::CHAN_RECIP_W)'(lhr_pkg::CHAN_RECIP);
        return prod[lhr_pkg::CHAN_SHIFT+9:lhr_pkg::CHAN_SHIFT];
    endfunction

    function automatic logic [7:0] clamp_byte(input logic [9:0] q);
        return (q > 10'd255) ? 8'd255 : q[7:0];
    endfunction

    // Stage 5: offset numerator base + 2*A*s*m.
    assign prodm     = 24'(lvl_in.as) * 24'(hue_in.mult);
    assign onum_next = 24'(lvl_in.base) + {prodm[22:0], 1'b0};

    // Stage 7: clamp and place the three levels by sextant.
    assign oc = clamp_byte(oq_reg);
    assign cc = clamp_byte(cq_reg);
    assign bc = clamp_byte(bq_reg);

    always_comb begin
        out_data_next.slot = slot6_reg;
        if (grey6_reg) begin
            out_data_next.red   = lum6_reg;
            out_data_next.green = lum6_reg;
            out_data_next.blue  = lum6_reg;
        end else begin
            case (sext6_reg)
                lhr_pkg::SEXT_RED_YEL: begin
                    out_data_next.red = cc; out_data_next.green = oc; out_data_next.blue = bc;
                end
                lhr_pkg::SEXT_YEL_GRN: begin
                    out_data_next.red = oc; out_data_next.green = cc; out_data_next.blue = bc;
                end
                lhr_pkg::SEXT_GRN_CYN: begin
                    out_data_next.red = bc; out_data_next.green = cc; out_data_next.blue = oc;
                end
                lhr_pkg::SEXT_CYN_BLU: begin
                    out_data_next.red = bc; out_data_next.green = oc; out_data_next.blue = cc;
                end
                lhr_pkg::SEXT_BLU_MAG: begin
                    out_data_next.red = oc; out_data_next.green = bc; out_data_next.blue = cc;
                end
                default: begin
                    out_data_next.red = cc; out_data_next.green = bc; out_data_next.blue = oc;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg        <= 1'b0;
            v6_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            v5_reg        <= hue_in.valid;
            v6_reg        <= v5_reg;
            out_valid_reg <= v6_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            slot5_reg    <= hue_in.slot;
            sext5_reg    <= hue_in.sext;
            grey5_reg    <= lvl_in.grey;
            lum5_reg     <= lvl_in.lum;
            onum5_reg    <= onum_next;
            cnum5_reg    <= lvl_in.cnum;
            base5_reg    <= 24'(lvl_in.base);

            // Stage 6: exact floor of each numerator over the common denominator.
            slot6_reg    <= slot5_reg;
            sext6_reg    <= sext5_reg;
            grey6_reg    <= grey5_reg;
            lum6_reg     <= lum5_reg;
            oq_reg       <= chan_quot(onum5_reg);
            cq_reg       <= chan_quot(cnum5_reg);
            bq_reg       <= chan_quot(base5_reg);

            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED HSL to RGB unit testbench
// Streams LED positions and lightness bytes through the conversion unit at
// several saturation settings and checks every color that comes back against
// an independent integer model of the hue sweep and the HSL conversion.
// ----------------------------------------------------------------------------
module testbench;

    // Strip length and fixed-point denominator of the color model. Every
    // channel is an integer numerator over 2 * 255 * 60.
    localparam int unsigned STRIP_LEDS = 32;
    localparam int unsigned CHAN_DEN   = 30600;

    // Clock period and the number of cycles spent in reset.
    localparam int CLK_PERIOD_NS = 12;
    localparam int RESET_CYCLES  = 6;

    // The pipeline is seven stages deep. After the last result has arrived we
    // still let the clock run on before touching the saturation register.
    localparam int PIPE_SLACK = 12;

    // Bound on one drain, and the hard stop for the whole run.
    localparam int DRAIN_LIMIT   = 50000;
    localparam int TIMEOUT_NS    = 5000000;

    // Random stimulus is issued in blocks, one saturation setting per block.
    localparam int RAND_BLOCKS   = 12;
    localparam int BLOCK_PIXELS  = 125;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic              s_valid = 1'b0;
    logic              s_ready;
    lhr_pkg::lhr_in_t  s_data  = '0;

    logic              m_valid;
    logic              m_ready = 1'b0;
    lhr_pkg::lhr_out_t m_data;

    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [7:0]        cfg_data  = '0;

    // Pixels waiting to be driven, and the colors predicted for pixels that
    // the unit has already accepted, oldest first.
    lhr_pkg::lhr_in_t  pixel_q[$];
    lhr_pkg::lhr_out_t color_q[$];

    // Copy of the saturation register as the unit should currently hold it.
    logic [7:0] sat_shadow = lhr_pkg::SAT_RESET;

    // High for one cycle after an input transaction was taken at a rising edge.
    logic s_fire = 1'b0;

    // Chance, in percent, that the sender or the receiver sits out a cycle.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    int error_count   = 0;
    int colors_seen   = 0;
    int pixels_sent   = 0;
    int sat_writes    = 0;

    led_hsl_to_rgb_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever begin
            #(CLK_PERIOD_NS / 2) aclk = ~aclk;
        end
    end

    // Floor of a channel numerator, clamped to the byte range.
    function automatic logic [7:0] chan_floor(input int unsigned num);
        int unsigned q;
        q = num / CHAN_DEN;
        return (q > 255) ? 8'd255 : q[7:0];
    endfunction

    // Color the unit should produce for one LED at the given saturation. The
    // hue sweeps the wheel once over the strip and wraps for indices past its
    // end; the sextant decides which channel gets chroma, offset or baseline.
    function automatic lhr_pkg::lhr_out_t hsl_color(input logic [9:0] idx,
                                                    input logic [7:0] lum,
                                                    input logic [7:0] sat);
        int unsigned hue, hue_mod, dev, ramp, twol, amp, amp_sat;
        int unsigned base_num, chroma_num, offset_num;
        logic [7:0]  base_ch, chroma_ch, offset_ch;
        logic [2:0]  sextant;
        lhr_pkg::lhr_out_t res;

        hue     = ((32'(idx) * 360) / STRIP_LEDS) % 360;
        sextant = 3'(hue / 60);
        hue_mod = hue % 120;
        dev     = (hue_mod >= 60) ? hue_mod - 60 : 60 - hue_mod;
        ramp    = 60 - dev;

        // 255 - |2l - 255| without ever going negative.
        twol    = 2 * 32'(lum);
        amp     = (twol >= 255) ? 510 - twol : twol;
        amp_sat = amp * 32'(sat);

        base_num   = CHAN_DEN * 32'(lum) - 60 * amp_sat;
        chroma_num = base_num + 120 * amp_sat;
        offset_num = base_num + 2 * amp_sat * ramp;

        base_ch   = chan_floor(base_num);
        chroma_ch = chan_floor(chroma_num);
        offset_ch = chan_floor(offset_num);

        res.slot = idx;
        if (sat == 8'd0) begin
            // No saturation means pure grey at the lightness level.
            res.red   = lum;
            res.green = lum;
            res.blue  = lum;
        end else begin
            case (sextant)
                lhr_pkg::SEXT_RED_YEL: begin
                    res.red = chroma_ch; res.green = offset_ch; res.blue = base_ch;
                end
                lhr_pkg::SEXT_YEL_GRN: begin
                    res.red = offset_ch; res.green = chroma_ch; res.blue = base_ch;
                end
                lhr_pkg::SEXT_GRN_CYN: begin
                    res.red = base_ch; res.green = chroma_ch; res.blue = offset_ch;
                end
                lhr_pkg::SEXT_CYN_BLU: begin
                    res.red = base_ch; res.green = offset_ch; res.blue = chroma_ch;
                end
                lhr_pkg::SEXT_BLU_MAG: begin
                    res.red = offset_ch; res.green = base_ch; res.blue = chroma_ch;
                end
                default: begin
                    res.red = chroma_ch; res.green = base_ch; res.blue = offset_ch;
                end
            endcase
        end
        return res;
    endfunction

    // Prints one line per failure and keeps the tally for the final verdict.
    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic queue_pixel(input int idx, input int lum);
        lhr_pkg::lhr_in_t px;
        px.led_index = 10'(idx);
        px.lightness = 8'(lum);
        pixel_q.push_back(px);
    endtask

    // Waits until every queued pixel has been sent and every predicted color
    // has come back, then lets the pipeline settle. No new pixel is queued
    // meanwhile, so this is also the point where the sender holds off until
    // the unit has gone completely quiet.
    task automatic drain_results();
        int waited;
        waited = 0;
        while ((pixel_q.size() != 0 || s_valid || color_q.size() != 0)
               && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            #1;
            waited++;
        end
        if (color_q.size() != 0) begin
            report_mismatch($sformatf("%0d expected colors never arrived",
                                      color_q.size()));
            color_q.delete();
        end
        repeat (PIPE_SLACK) @(posedge aclk);
    endtask

    // Writes the saturation register through its own channel. Only called
    // while the unit is idle.
    task automatic write_saturation(input logic [7:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        sat_writes++;
    endtask

    // Input driver. At each falling edge it either holds the pending
    // transaction or, once that was taken, offers the next pixel unless it
    // decides to idle this cycle. The receiver's ready is chosen here as well.
    always @(negedge aclk) begin
        if (!s_valid || s_fire) begin
            if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_data  <= pixel_q.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Monitor. Everything is sampled at the rising edge: accepted input
    // transactions get their color predicted with the saturation in force,
    // accepted result transactions are checked against the oldest prediction.
    always @(posedge aclk) begin
        s_fire <= aresetn && s_valid && s_ready;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                sat_shadow <= cfg_data;
            end
            if (s_valid && s_ready) begin
                color_q.push_back(hsl_color(s_data.led_index, s_data.lightness,
                                            sat_shadow));
                pixels_sent++;
            end
            if (m_valid && m_ready) begin
                colors_seen++;
                if (color_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected color for slot %0d",
                                              m_data.slot));
                end else begin
                    lhr_pkg::lhr_out_t want;
                    want = color_q.pop_front();
                    if (m_data.slot !== want.slot)
                        report_mismatch($sformatf("slot got %0d want %0d",
                                                  m_data.slot, want.slot));
                    if (m_data.red !== want.red)
                        report_mismatch($sformatf("slot %0d red got %0d want %0d",
                                                  want.slot, m_data.red, want.red));
                    if (m_data.green !== want.green)
                        report_mismatch($sformatf("slot %0d green got %0d want %0d",
                                                  want.slot, m_data.green, want.green));
                    if (m_data.blue !== want.blue)
                        report_mismatch($sformatf("slot %0d blue got %0d want %0d",
                                                  want.slot, m_data.blue, want.blue));
                end
            end
        end
    end

    // Stimulus sequence: directed pixels at the reset saturation and at zero
    // saturation, then random blocks that each run at their own setting.
    initial begin
        int sat_plan[RAND_BLOCKS];
        int blk, n, idx, lum, pick;
        logic [7:0] sat_val;
        int lum_edges[6];

        sat_plan  = '{255, 1, 0, 128, -1, 254, -1, 127, 0, -1, 255, 1};
        lum_edges = '{0, 1, 127, 128, 254, 255};

        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);

        send_idle_pct = 9;
        recv_idle_pct = 76;

        // Directed pixels at full saturation straight out of reset: the index
        // and lightness extremes, one LED in each hue sextant, the sextant
        // borders, and indices past the strip end where the hue wraps.
        queue_pixel(0, 0);
        queue_pixel(0, 255);
        queue_pixel(1023, 0);
        queue_pixel(1023, 255);
        queue_pixel(6, 128);
        queue_pixel(11, 127);
        queue_pixel(16, 200);
        queue_pixel(22, 64);
        queue_pixel(27, 100);
        queue_pixel(31, 1);
        queue_pixel(32, 128);
        queue_pixel(5, 254);
        queue_pixel(10, 128);
        queue_pixel(21, 128);
        queue_pixel(26, 128);
        drain_results();

        // Zero saturation must give grey at the lightness level.
        write_saturation(8'd0);
        queue_pixel(0, 0);
        queue_pixel(13, 77);
        queue_pixel(1023, 255);
        queue_pixel(700, 128);
        drain_results();

        for (blk = 0; blk < RAND_BLOCKS; blk++) begin
            // Sender nearly always busy with a slow receiver first, then the
            // reverse, and the last third runs with both sides flat out.
            if (blk < RAND_BLOCKS / 3) begin
                send_idle_pct = 9;
                recv_idle_pct = 76;
            end else if (blk < 2 * RAND_BLOCKS / 3) begin
                send_idle_pct = 76;
                recv_idle_pct = 9;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            sat_val = (sat_plan[blk] < 0) ? 8'($urandom_range(255)) : 8'(sat_plan[blk]);
            write_saturation(sat_val);

            for (n = 0; n < BLOCK_PIXELS; n++) begin
                // Mostly LEDs on the strip, a good share of arbitrary indices
                // so every index bit moves and the hue wraps, lightness mostly
                // random with its boundary values mixed in.
                pick = $urandom_range(99);
                if (pick < 65)
                    idx = $urandom_range(STRIP_LEDS - 1);
                else if (pick < 95)
                    idx = $urandom_range(1023);
                else
                    idx = ($urandom_range(1) != 0) ? 1023 : STRIP_LEDS;
                if ($urandom_range(9) == 0)
                    lum = lum_edges[$urandom_range(5)];
                else
                    lum = $urandom_range(255);
                queue_pixel(idx, lum);
            end
            drain_results();
        end

        $display("Checked %0d colors from %0d pixels across %0d saturation writes,",
                 colors_seen, pixels_sent, sat_writes);
        $display("covering every hue sextant, wrapped indices and grey output.");
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Hard stop in case the unit hangs on either channel.
    initial begin
        #(TIMEOUT_NS);
        $display("Regression FAIL");
        $finish;
    end

endmodule

/* led_hsl_to_rgb_unit.f */
rtl/core/lhr_pkg.sv
rtl/core/lhr_hue_pipe.sv
rtl/core/lhr_level_pipe.sv
rtl/core/lhr_channel_pipe.sv
rtl/core/led_hsl_to_rgb_unit.sv
bench/testbench.sv
